[design/ufn_pkg.sv]
// Shared types and constants for the UTF-8 fullwidth normalizer.
`default_nettype none
package ufn_pkg;

  localparam int JOBQ_DEPTH = 4;
  localparam int JOBQ_AW    = $clog2(JOBQ_DEPTH);
  localparam int JOBQ_CW    = $clog2(JOBQ_DEPTH + 1);

  localparam logic [7:0]  ASCII_LIMIT  = 8'h80;
  localparam logic [7:0]  ASCII_SPACE  = 8'h20;
  localparam logic [7:0]  LEAD2_MASK   = 8'hE0;
  localparam logic [7:0]  LEAD2_CODE   = 8'hC0;
  localparam logic [7:0]  LEAD3_MASK   = 8'hF0;
  localparam logic [7:0]  LEAD3_CODE   = 8'hE0;
  // fullwidth code points and the low-byte offset to their ASCII forms
  localparam logic [15:0] CP_IDEO_SPACE = 16'h3000;
  localparam logic [15:0] CP_UPPER_LO   = 16'hFF21;
  localparam logic [15:0] CP_UPPER_HI   = 16'hFF3A;
  localparam logic [15:0] CP_LOWER_LO   = 16'hFF41;
  localparam logic [15:0] CP_LOWER_HI   = 16'hFF5A;
  localparam logic [15:0] CP_DIGIT_LO   = 16'hFF10;
  localparam logic [15:0] CP_DIGIT_HI   = 16'hFF19;
  localparam logic [7:0]  FW_OFFSET     = 8'h20;

  typedef enum logic [1:0] {
    SEQ_NONE,
    SEQ_TWO,
    SEQ_THREE_A,
    SEQ_THREE_B
  } seq_state_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       string_last;
  } in_item_t;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;
  } out_item_t;

  // one queued request: up to three bytes, or a bare end marker
  typedef struct packed {
    logic [1:0] nres;
    logic       has_byte;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic       str_end;
  } job_t;

endpackage
`default_nettype wire

[design/utf8_fullwidth_normalizer.sv]
// The first result of an input passes the job queue, then the output register;
// further results of the same input follow one per cycle while the output is
// popped. Throughput: one input byte per cycle while the job queue has room; the
// emitter drains one byte per cycle while popped, so a three-byte passthrough
// ties it up and the job queue absorbs the burst. Reset (rst_n, synchronous)
// drops any pending sequence and empties the queue and output register.
`default_nettype none
module utf8_fullwidth_normalizer (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  output logic                full,
  input  ufn_pkg::in_item_t   in_data,
  output logic                empty,
  input  wire                 pop,
  output ufn_pkg::out_item_t  out_data
);

  logic          accept;
  logic          job_push;
  ufn_pkg::job_t job_in;
  ufn_pkg::job_t job_head;
  logic          job_valid;
  logic          job_pop;
  logic          q_full;

  assign full   = q_full;
  assign accept = push && !q_full;

  ufn_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .item     (in_data),
    .job_push (job_push),
    .job      (job_in)
  );

  ufn_jobq u_jobq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (job_push),
    .wr_job  (job_in),
    .rd_en   (job_pop),
    .rd_job  (job_head),
    .q_full  (q_full),
    .q_valid (job_valid)
  );

  ufn_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (job_head),
    .job_pop   (job_pop),
    .pop       (pop),
    .empty     (empty),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

[design/ufn_front.sv]
// Front end: tracks UTF-8 sequences and turns an input byte into an output job when it yields bytes or ends the string.
`default_nettype none
module ufn_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 accept,
  input  ufn_pkg::in_item_t   item,
  output logic                job_push,
  output ufn_pkg::job_t       job
);

  ufn_pkg::seq_state_t state_r, state_nxt;
  logic [7:0]  held0_r, held0_nxt;
  logic [7:0]  held1_r, held1_nxt;
  logic [7:0]  c;
  logic [15:0] cp;
  logic [1:0]  n;
  logic        fw_map;

  assign c  = item.in_byte;
  assign cp = {held0_r[3:0], held1_r[5:0], c[5:0]};
  assign fw_map = (cp >= ufn_pkg::CP_UPPER_LO && cp <= ufn_pkg::CP_UPPER_HI)
               || (cp >= ufn_pkg::CP_LOWER_LO && cp <= ufn_pkg::CP_LOWER_HI)
               || (cp >= ufn_pkg::CP_DIGIT_LO && cp <= ufn_pkg::CP_DIGIT_HI);

  always_comb begin
    state_nxt = state_r;
    held0_nxt = held0_r;
    held1_nxt = held1_r;
    if (accept) begin
      unique case (state_r)
        ufn_pkg::SEQ_NONE: begin
          if (c >= ufn_pkg::ASCII_LIMIT) begin
            if ((c & ufn_pkg::LEAD2_MASK) == ufn_pkg::LEAD2_CODE) begin
              state_nxt = ufn_pkg::SEQ_TWO;
              held0_nxt = c;
            end else if ((c & ufn_pkg::LEAD3_MASK) == ufn_pkg::LEAD3_CODE) begin
              state_nxt = ufn_pkg::SEQ_THREE_A;
              held0_nxt = c;
            end
          end
        end
        ufn_pkg::SEQ_TWO:     state_nxt = ufn_pkg::SEQ_NONE;
        ufn_pkg::SEQ_THREE_A: begin
          state_nxt = ufn_pkg::SEQ_THREE_B;
          held1_nxt = c;
        end
        ufn_pkg::SEQ_THREE_B: state_nxt = ufn_pkg::SEQ_NONE;
        default:              state_nxt = ufn_pkg::SEQ_NONE;
      endcase
      // a pending sequence is dropped at end of string
      if (item.string_last) state_nxt = ufn_pkg::SEQ_NONE;
    end
  end

  always_comb begin
    n  = 2'd0;
    job.b0 = c;
    job.b1 = c;
    job.b2 = c;
    unique case (state_r)
      ufn_pkg::SEQ_NONE: begin
        if (c < ufn_pkg::ASCII_LIMIT) begin
          if (c != ufn_pkg::ASCII_SPACE) n = 2'd1;
        end else if ((c & ufn_pkg::LEAD2_MASK) != ufn_pkg::LEAD2_CODE &&
                     (c & ufn_pkg::LEAD3_MASK) != ufn_pkg::LEAD3_CODE) begin
          n = 2'd1;
        end
      end
      ufn_pkg::SEQ_TWO: begin
        n = 2'd2;
        job.b0 = held0_r;
      end
      ufn_pkg::SEQ_THREE_A: n = 2'd0;
      ufn_pkg::SEQ_THREE_B: begin
        if (cp == ufn_pkg::CP_IDEO_SPACE) begin
          n = 2'd0;
        end else if (fw_map) begin
          n = 2'd1;
          job.b0 = cp[7:0] + ufn_pkg::FW_OFFSET;
        end else begin
          n = 2'd3;
          job.b0 = held0_r;
          job.b1 = held1_r;
        end
      end
      default: n = 2'd0;
    endcase
    job.has_byte = (n != 2'd0);
    job.nres     = (n == 2'd0) ? 2'd1 : n;
    job.str_end  = item.string_last;
    job_push     = accept && ((n != 2'd0) || item.string_last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ufn_pkg::SEQ_NONE;
    end else begin
      state_r <= state_nxt;
    end
    held0_r <= held0_nxt;
    held1_r <= held1_nxt;
  end

endmodule
`default_nettype wire

[design/ufn_jobq.sv]
// Short job queue between the front end and the byte emitter.
`default_nettype none
module ufn_jobq (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 wr_en,
  input  ufn_pkg::job_t       wr_job,
  input  wire                 rd_en,
  output ufn_pkg::job_t       rd_job,
  output logic                q_full,
  output logic                q_valid
);

  ufn_pkg::job_t mem [ufn_pkg::JOBQ_DEPTH];
  logic [ufn_pkg::JOBQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [ufn_pkg::JOBQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [ufn_pkg::JOBQ_CW-1:0] cnt_r, cnt_nxt;

  assign q_full  = (cnt_r == ufn_pkg::JOBQ_CW'(ufn_pkg::JOBQ_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign rd_job  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + ufn_pkg::JOBQ_AW'(wr_en);
    rd_ptr_nxt = rd_ptr_r + ufn_pkg::JOBQ_AW'(rd_en);
    cnt_nxt    = cnt_r + ufn_pkg::JOBQ_CW'(wr_en) - ufn_pkg::JOBQ_CW'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr_r] <= wr_job;
  end

endmodule
`default_nettype wire

[design/ufn_back.sv]
// Back end: walks each job one byte per cycle, while the output register is free or popped, into that register.
`default_nettype none
module ufn_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 job_valid,
  input  ufn_pkg::job_t       job,
  output logic                job_pop,
  input  wire                 pop,
  output logic                empty,
  output ufn_pkg::out_item_t  out_data
);

  logic                out_vld_r, out_vld_nxt;
  ufn_pkg::out_item_t  out_r, out_nxt;
  logic [1:0]          idx_r, idx_nxt;
  logic                load;
  logic                tail;
  logic [7:0]          sel_byte;

  assign load = job_valid && (!out_vld_r || pop);
  assign tail = (idx_r == job.nres - 2'd1);

  always_comb begin
    case (idx_r)
      2'd0:    sel_byte = job.b0;
      2'd1:    sel_byte = job.b1;
      default: sel_byte = job.b2;
    endcase
  end

  always_comb begin
    out_nxt     = out_r;
    idx_nxt     = idx_r;
    job_pop     = 1'b0;
    out_vld_nxt = out_vld_r && !pop;
    if (load) begin
      out_vld_nxt         = 1'b1;
      out_nxt.has_byte    = job.has_byte;
      out_nxt.out_byte    = job.has_byte ? sel_byte : 8'h00;
      out_nxt.run_last    = tail;
      out_nxt.string_end  = tail && job.str_end;
      job_pop             = tail;
      idx_nxt             = tail ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      idx_r     <= 2'd0;
    end else begin
      out_vld_r <= out_vld_nxt;
      idx_r     <= idx_nxt;
    end
    out_r <= out_nxt;
  end

  assign empty    = !out_vld_r;
  assign out_data = out_r;

  a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.string_end) |-> out_r.run_last)
    else $error("string_end without run_last");

  a_bare_marker: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_r.has_byte) |-> (out_r.out_byte == 8'h00 && out_r.string_end))
    else $error("bare end marker malformed");

  a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid |-> (idx_r < job.nres))
    else $error("byte index past job length");

  a_pop_on_tail: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |=> (idx_r == 2'd0))
    else $error("index not rewound after job");

endmodule
`default_nettype wire
